>>> rtl/bbl_pkg.sv
// Shared types and constants of the byte budget LRU tag unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package bbl_pkg;

   localparam int ENTRIES_DEF = 32;

   localparam int TAG_W   = 64;
   localparam int SIZE_W  = 31;
   localparam int STAMP_W = 64;
   localparam int TOTAL_W = 32;
   localparam int KIND_W  = 3;
   localparam int CSR_IDX_W = 1;
   localparam int WORD_W  = TAG_W + SIZE_W + STAMP_W;

   localparam logic [SIZE_W-1:0] BYTE_LIMIT_RESET = SIZE_W'(16 * 1024 * 1024);
   localparam logic [SIZE_W-1:0] MAX_ITEM_RESET   = SIZE_W'(6 * 1024 * 1024);

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITEM   = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_HIT      = 3'd0,
      KIND_MISS     = 3'd1,
      KIND_STORED   = 3'd2,
      KIND_REJECTED = 3'd3,
      KIND_EVICTED  = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_REJECT,
      ST_SCAN_FIRST,
      ST_LOOKUP_END,
      ST_PLACE,
      ST_FULL_EVICT,
      ST_STORE,
      ST_BUDGET_CHECK,
      ST_SCAN_BUDGET,
      ST_BUDGET_EVICT
   } state_type;

   typedef struct packed {
      logic     load;
      logic     scan_start;
      logic     place;
      logic     evict;
      logic     store;
      logic     touch;
      logic     emit;
      kind_type kind;
      logic     last_always;
      logic     last_if_fits;
   } cmd_type;

   typedef struct packed {
      logic is_insert;
      logic reject;
      logic scan_done;
      logic found;
      logic free_found;
      logic over;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/bbl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module bbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/bbl_datapath.sv
// Datapath: configuration registers, entry table RAM, scan trackers,
// byte and entry counters and the result register. Depends on bbl_pkg and bbl_ram.
`default_nettype none

module bbl_datapath #(
   parameter int ENTRIES = bbl_pkg::ENTRIES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire bbl_pkg::cmd_type               cmd,
   output bbl_pkg::status_type                 status,
   input  wire logic                           req_operation,
   input  wire logic [bbl_pkg::TAG_W-1:0]      req_key_tag,
   input  wire logic [bbl_pkg::SIZE_W-1:0]     req_item_bytes,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [bbl_pkg::KIND_W-1:0]          rsp_kind,
   output logic [bbl_pkg::TAG_W-1:0]           rsp_victim_tag,
   output logic [bbl_pkg::SIZE_W-1:0]          rsp_victim_bytes,
   output logic [bbl_pkg::TOTAL_W-1:0]         rsp_total_bytes,
   output logic                                rsp_last,
   input  wire logic                           csr_wr_en,
   input  wire logic [bbl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bbl_pkg::SIZE_W-1:0]     csr_wdata
);

   import bbl_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   // configuration
   logic [SIZE_W-1:0] limit_ff, limit_in;
   logic [SIZE_W-1:0] max_ff, max_in;

   // captured word
   logic              op_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [SIZE_W-1:0] bytes_ff;

   // bookkeeping
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [TOTAL_W-1:0] held_ff, held_in;
   logic [STAMP_W-1:0] counter_ff, counter_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;

   // scan
   logic               scan_active_ff, scan_active_in;
   logic [IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic               data_valid_ff, data_valid_in;
   logic [IDX_W-1:0]   data_idx_ff, data_idx_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   match_idx_ff, match_idx_in;
   logic [SIZE_W-1:0]  match_size_ff, match_size_in;
   logic               have_old_ff, have_old_in;
   logic [IDX_W-1:0]   old_idx_ff, old_idx_in;
   logic [TAG_W-1:0]   old_tag_ff, old_tag_in;
   logic [SIZE_W-1:0]  old_size_ff, old_size_in;
   logic [STAMP_W-1:0] old_stamp_ff, old_stamp_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  kind_ff;
   logic [TAG_W-1:0]   vtag_ff;
   logic [SIZE_W-1:0]  vbytes_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic               last_ff;

   // RAM
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [WORD_W-1:0]  wr_data;
   logic [WORD_W-1:0]  rd_data;
   logic [TAG_W-1:0]   rd_tag;
   logic [SIZE_W-1:0]  rd_size;
   logic [STAMP_W-1:0] rd_stamp;
   logic [STAMP_W-1:0] stamp_new;

   logic               free_found;
   logic [IDX_W-1:0]   free_idx;
   logic               over_next;
   logic               entry_live;

   bbl_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_data)
   );

   assign rd_tag   = rd_data[WORD_W-1 -: TAG_W];
   assign rd_size  = rd_data[STAMP_W +: SIZE_W];
   assign rd_stamp = rd_data[STAMP_W-1:0];
   assign stamp_new = counter_ff + STAMP_W'(1);

   always_comb begin
      free_found = ~&valid_ff;
      free_idx   = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      limit_in = limit_ff;
      max_in   = max_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BYTE_LIMIT: limit_in = csr_wdata;
            CSR_MAX_ITEM:   max_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      scan_active_in = scan_active_ff;
      scan_idx_in    = scan_idx_ff;
      data_valid_in  = scan_active_ff;
      data_idx_in    = scan_idx_ff;
      found_in       = found_ff;
      match_idx_in   = match_idx_ff;
      match_size_in  = match_size_ff;
      have_old_in    = have_old_ff;
      old_idx_in     = old_idx_ff;
      old_tag_in     = old_tag_ff;
      old_size_in    = old_size_ff;
      old_stamp_in   = old_stamp_ff;
      entry_live     = valid_ff[data_idx_ff];

      if (cmd.scan_start) begin
         scan_active_in = 1'b1;
         scan_idx_in    = '0;
         found_in       = 1'b0;
         have_old_in    = 1'b0;
      end else if (scan_active_ff) begin
         if (scan_idx_ff == LAST_IDX) begin
            scan_active_in = 1'b0;
         end else begin
            scan_idx_in = scan_idx_ff + IDX_W'(1);
         end
      end

      if (data_valid_ff && entry_live) begin
         if (!found_ff && rd_tag == tag_ff) begin
            found_in      = 1'b1;
            match_idx_in  = data_idx_ff;
            match_size_in = rd_size;
         end
         if (!have_old_ff || rd_stamp < old_stamp_ff) begin
            have_old_in  = 1'b1;
            old_idx_in   = data_idx_ff;
            old_tag_in   = rd_tag;
            old_size_in  = rd_size;
            old_stamp_in = rd_stamp;
         end
      end
   end

   always_comb begin
      valid_in   = valid_ff;
      cnt_in     = cnt_ff;
      held_in    = held_ff;
      counter_in = counter_ff;
      slot_in    = slot_ff;

      if (cmd.place) begin
         if (found_ff) begin
            slot_in = match_idx_ff;
            held_in = held_in - TOTAL_W'(match_size_ff);
         end else if (free_found) begin
            slot_in = free_idx;
         end else begin
            slot_in = old_idx_ff;
         end
      end
      if (cmd.evict) begin
         valid_in[old_idx_ff] = 1'b0;
         cnt_in  = cnt_ff - CNT_W'(1);
         held_in = held_in - TOTAL_W'(old_size_ff);
      end
      if (cmd.store) begin
         valid_in[slot_ff] = 1'b1;
         if (!valid_ff[slot_ff]) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
         held_in = held_in + TOTAL_W'(bytes_ff);
      end
      if (cmd.store || cmd.touch) begin
         counter_in = stamp_new;
      end

      over_next = (held_in > TOTAL_W'(limit_in)) && (cnt_in > CNT_W'(1));
   end

   always_comb begin
      wr_en   = cmd.store || cmd.touch;
      wr_addr = cmd.store ? slot_ff : match_idx_ff;
      wr_data = cmd.store ? {tag_ff, bytes_ff, stamp_new} : {tag_ff, match_size_ff, stamp_new};
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff       <= BYTE_LIMIT_RESET;
         max_ff         <= MAX_ITEM_RESET;
         valid_ff       <= '0;
         cnt_ff         <= '0;
         held_ff        <= '0;
         counter_ff     <= '0;
         scan_active_ff <= 1'b0;
         data_valid_ff  <= 1'b0;
         found_ff       <= 1'b0;
         have_old_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         limit_ff       <= limit_in;
         max_ff         <= max_in;
         valid_ff       <= valid_in;
         cnt_ff         <= cnt_in;
         held_ff        <= held_in;
         counter_ff     <= counter_in;
         scan_active_ff <= scan_active_in;
         data_valid_ff  <= data_valid_in;
         found_ff       <= found_in;
         have_old_ff    <= have_old_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      data_idx_ff   <= data_idx_in;
      match_idx_ff  <= match_idx_in;
      match_size_ff <= match_size_in;
      old_idx_ff    <= old_idx_in;
      old_tag_ff    <= old_tag_in;
      old_size_ff   <= old_size_in;
      old_stamp_ff  <= old_stamp_in;
      slot_ff       <= slot_in;
      if (cmd.load) begin
         op_ff    <= req_operation;
         tag_ff   <= req_key_tag;
         bytes_ff <= req_item_bytes;
      end
      if (cmd.emit) begin
         kind_ff   <= cmd.kind;
         vtag_ff   <= (cmd.kind == KIND_EVICTED) ? old_tag_ff : '0;
         vbytes_ff <= (cmd.kind == KIND_EVICTED) ? old_size_ff : '0;
         total_ff  <= held_in;
         last_ff   <= cmd.last_always || (cmd.last_if_fits && !over_next);
      end
   end

   always_comb begin
      status.is_insert  = (op_ff == OP_INSERT);
      status.reject     = (bytes_ff == '0) || (bytes_ff > max_ff);
      status.scan_done  = data_valid_ff && (data_idx_ff == LAST_IDX);
      status.found      = found_ff;
      status.free_found = free_found;
      status.over       = (held_ff > TOTAL_W'(limit_ff)) && (cnt_ff > CNT_W'(1));
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_victim_tag   = vtag_ff;
   assign rsp_victim_bytes = vbytes_ff;
   assign rsp_total_bytes  = total_ff;
   assign rsp_last         = last_ff;

endmodule

`default_nettype wire

>>> rtl/bbl_ctrl.sv
// Controller state machine: sequences capture, table scans, placement,
// eviction and result emission. Depends on bbl_pkg.
`default_nettype none

module bbl_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire bbl_pkg::status_type  status,
   output bbl_pkg::cmd_type          cmd
);

   import bbl_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.kind  = KIND_HIT;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (status.is_insert && status.reject) begin
               state_in = ST_REJECT;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN_FIRST;
            end
         end
         ST_REJECT: begin
            if (status.out_free) begin
               cmd.emit        = 1'b1;
               cmd.kind        = KIND_REJECTED;
               cmd.last_always = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_SCAN_FIRST: begin
            if (status.scan_done) begin
               state_in = status.is_insert ? ST_PLACE : ST_LOOKUP_END;
            end
         end
         ST_LOOKUP_END: begin
            if (status.out_free) begin
               cmd.emit        = 1'b1;
               cmd.last_always = 1'b1;
               cmd.touch       = status.found;
               cmd.kind        = status.found ? KIND_HIT : KIND_MISS;
               state_in        = ST_IDLE;
            end
         end
         ST_PLACE: begin
            if (status.found || status.free_found) begin
               cmd.place = 1'b1;
               state_in  = ST_STORE;
            end else begin
               state_in  = ST_FULL_EVICT;
            end
         end
         ST_FULL_EVICT: begin
            if (status.out_free) begin
               cmd.place = 1'b1;
               cmd.evict = 1'b1;
               cmd.emit  = 1'b1;
               cmd.kind  = KIND_EVICTED;
               state_in  = ST_STORE;
            end
         end
         ST_STORE: begin
            if (status.out_free) begin
               cmd.store        = 1'b1;
               cmd.emit         = 1'b1;
               cmd.kind         = KIND_STORED;
               cmd.last_if_fits = 1'b1;
               state_in         = ST_BUDGET_CHECK;
            end
         end
         ST_BUDGET_CHECK: begin
            if (status.over) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN_BUDGET;
            end else begin
               state_in       = ST_IDLE;
            end
         end
         ST_SCAN_BUDGET: begin
            if (status.scan_done) begin
               state_in = ST_BUDGET_EVICT;
            end
         end
         ST_BUDGET_EVICT: begin
            if (status.out_free) begin
               cmd.evict        = 1'b1;
               cmd.emit         = 1'b1;
               cmd.kind         = KIND_EVICTED;
               cmd.last_if_fits = 1'b1;
               state_in         = ST_BUDGET_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/byte_budget_lru_cache_tags_unit.sv
// Top level of the byte budget LRU tag unit.
// Joins bbl_ctrl and bbl_datapath; depends on bbl_pkg.
`default_nettype none

// The unit keeps tag, size and use stamp of up to ENTRIES cached items in one
// table RAM and answers one request word at a time. Every pass over the table
// reads one entry per cycle; a lookup makes one pass and an insert one pass,
// plus one more pass for every entry evicted to bring the held total within
// byte_limit; a rejected insert makes no pass.
// Each request gives one or more response words, the final one flagged by
// rsp_last. A new request is taken once the previous one has queued its final
// word, even while that word still waits in the output register. A stall on
// rsp_ready holds the unit in each state that emits a word.
module byte_budget_lru_cache_tags_unit #(
   parameter int ENTRIES = bbl_pkg::ENTRIES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_operation,
   input  wire logic [bbl_pkg::TAG_W-1:0]      req_key_tag,
   input  wire logic [bbl_pkg::SIZE_W-1:0]     req_item_bytes,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [bbl_pkg::KIND_W-1:0]          rsp_kind,
   output logic [bbl_pkg::TAG_W-1:0]           rsp_victim_tag,
   output logic [bbl_pkg::SIZE_W-1:0]          rsp_victim_bytes,
   output logic [bbl_pkg::TOTAL_W-1:0]         rsp_total_bytes,
   output logic                                rsp_last,
   input  wire logic                           csr_wr_en,
   input  wire logic [bbl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bbl_pkg::SIZE_W-1:0]     csr_wdata
);

   import bbl_pkg::*;

   cmd_type    cmd;
   status_type status;

   bbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bbl_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_key_tag      (req_key_tag),
      .req_item_bytes   (req_item_bytes),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_victim_tag   (rsp_victim_tag),
      .rsp_victim_bytes (rsp_victim_bytes),
      .rsp_total_bytes  (rsp_total_bytes),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

endmodule

`default_nettype wire

>>> bench/tb_byte_budget_lru_cache_tags_unit.sv
// Self-checking bench of byte_budget_lru_cache_tags_unit: directed and random lookups and
// inserts, checked word by word against a tag, size and stamp table kept in the bench.
// Depends on bbl_pkg and the top level of the unit.
`timescale 1ns / 100ps
`default_nettype none

module tb_byte_budget_lru_cache_tags_unit;
   import bbl_pkg::*;

   localparam int SLOTS       = ENTRIES_DEF;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 4000;
   localparam int POOL_MAX    = 48;

   typedef struct {
      kind_type            kind;
      logic [TAG_W-1:0]    victim_tag;
      logic [SIZE_W-1:0]   victim_bytes;
      logic [TOTAL_W-1:0]  total_bytes;
      logic                last;
   } cache_word_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_operation;
   logic [TAG_W-1:0]     req_key_tag;
   logic [SIZE_W-1:0]    req_item_bytes;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [KIND_W-1:0]    rsp_kind;
   logic [TAG_W-1:0]     rsp_victim_tag;
   logic [SIZE_W-1:0]    rsp_victim_bytes;
   logic [TOTAL_W-1:0]   rsp_total_bytes;
   logic                 rsp_last;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SIZE_W-1:0]    csr_wdata;

   // bench copy of the cache table
   logic                 slot_live  [SLOTS];
   logic [TAG_W-1:0]     slot_tag   [SLOTS];
   logic [SIZE_W-1:0]    slot_size  [SLOTS];
   logic [STAMP_W-1:0]   slot_stamp [SLOTS];
   logic [STAMP_W-1:0]   use_stamp;
   logic [63:0]          held_total;
   int                   live_count;
   logic [SIZE_W-1:0]    limit_bytes;
   logic [SIZE_W-1:0]    item_cap;

   cache_word_type       due_words [$];
   cache_word_type       op_words  [$];
   logic [TAG_W-1:0]     tag_pool  [POOL_MAX];

   int                   failures;
   int                   quiet_cycles;
   bit                   steady;
   bit                   sink_hold_req;

   byte_budget_lru_cache_tags_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_key_tag      (req_key_tag),
      .req_item_bytes   (req_item_bytes),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_victim_tag   (rsp_victim_tag),
      .rsp_victim_bytes (rsp_victim_bytes),
      .rsp_total_bytes  (rsp_total_bytes),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int find_tag(input logic [TAG_W-1:0] tag);
      int hit;
      int i;
      hit = -1;
      for (i = SLOTS - 1; i >= 0; i--)
         if (slot_live[i] && slot_tag[i] == tag) hit = i;
      return hit;
   endfunction

   function automatic int oldest_slot();
      int best;
      int i;
      best = -1;
      for (i = 0; i < SLOTS; i++)
         if (slot_live[i] && (best < 0 || slot_stamp[i] < slot_stamp[best])) best = i;
      return best;
   endfunction

   function automatic void add_word(input kind_type kind, input logic [TAG_W-1:0] tag,
                                    input logic [SIZE_W-1:0] nbytes);
      cache_word_type w;
      w.kind         = kind;
      w.victim_tag   = tag;
      w.victim_bytes = nbytes;
      w.total_bytes  = held_total[TOTAL_W-1:0];
      w.last         = 1'b0;
      op_words = {op_words, w};
   endfunction

   function automatic void drop_slot(input int slot);
      slot_live[slot] = 1'b0;
      held_total -= slot_size[slot];
      live_count--;
      add_word(KIND_EVICTED, slot_tag[slot], slot_size[slot]);
   endfunction

   task automatic predict_cache_op(input logic op, input logic [TAG_W-1:0] tag,
                                   input logic [SIZE_W-1:0] nbytes);
      int slot;
      int i;
      int tail;
      cache_word_type w;
      slot = find_tag(tag);
      if (op == OP_LOOKUP) begin
         if (slot >= 0) begin
            use_stamp++;
            slot_stamp[slot] = use_stamp;
            add_word(KIND_HIT, '0, '0);
         end else begin
            add_word(KIND_MISS, '0, '0);
         end
      end else if (nbytes == '0 || nbytes > item_cap) begin
         add_word(KIND_REJECTED, '0, '0);
      end else begin
         if (slot >= 0) begin
            held_total -= slot_size[slot];
         end else begin
            for (i = 0; i < SLOTS && slot < 0; i++)
               if (!slot_live[i]) slot = i;
            if (slot < 0) begin
               slot = oldest_slot();
               drop_slot(slot);
            end
            live_count++;
         end
         use_stamp++;
         slot_live[slot]  = 1'b1;
         slot_tag[slot]   = tag;
         slot_size[slot]  = nbytes;
         slot_stamp[slot] = use_stamp;
         held_total += nbytes;
         add_word(KIND_STORED, '0, '0);
         while (held_total > limit_bytes && live_count > 1)
            drop_slot(oldest_slot());
      end
      tail = op_words.size() - 1;
      w = op_words[tail];
      w.last = 1'b1;
      op_words[tail] = w;
      due_words = {due_words, op_words};
      op_words.delete();
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_word(input logic op, input logic [TAG_W-1:0] tag,
                            input logic [SIZE_W-1:0] nbytes);
      while (!steady && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_key_tag    <= tag;
      req_item_bytes <= nbytes;
      do @(posedge clock); while (!req_ready);
      predict_cache_op(op, tag, nbytes);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_BYTE_LIMIT) limit_bytes = value;
      else item_cap = value;
      @(negedge clock);
   endtask

   task automatic new_tag_pool();
      int i;
      for (i = 0; i < POOL_MAX; i++) tag_pool[i] = {$urandom, $urandom};
   endtask

   task automatic run_random(input int count, input int pool_n, input logic [SIZE_W-1:0] size_cap,
                             input int ins_pct, input bit wide);
      int i;
      logic op;
      logic [TAG_W-1:0] tag;
      logic [SIZE_W-1:0] nbytes;
      for (i = 0; i < count; i++) begin
         op  = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_LOOKUP;
         tag = tag_pool[$urandom_range(pool_n - 1)];
         if (op == OP_LOOKUP && $urandom_range(9) == 0) tag = {$urandom, $urandom};
         case ($urandom_range(19))
            0: nbytes = '0;
            1: nbytes = item_cap + 1'b1;
            2: nbytes = wide ? SIZE_W'($urandom) : SIZE_W'($urandom_range(size_cap, 1));
            default: nbytes = SIZE_W'($urandom_range(size_cap, 1));
         endcase
         send_word(op, tag, nbytes);
      end
   endtask

   task automatic test_reset_defaults();
      send_word(OP_LOOKUP, '0, '0);
      send_word(OP_INSERT, '0, '0);
      send_word(OP_INSERT, '0, MAX_ITEM_RESET + 1'b1);
      send_word(OP_INSERT, '0, MAX_ITEM_RESET);
      send_word(OP_LOOKUP, '0, '1);
      send_word(OP_INSERT, '1, MAX_ITEM_RESET);
      send_word(OP_INSERT, 64'h0123_4567_89AB_CDEF, MAX_ITEM_RESET);
      send_word(OP_INSERT, '1, SIZE_W'(1));
      send_word(OP_LOOKUP, '0, '0);
      send_word(OP_LOOKUP, '1, '0);
   endtask

   task automatic test_budget_limits();
      settle();
      write_csr(CSR_BYTE_LIMIT, SIZE_W'(100));
      write_csr(CSR_MAX_ITEM, SIZE_W'(60));
      send_word(OP_INSERT, 64'hA, SIZE_W'(60));
      send_word(OP_INSERT, 64'hB, SIZE_W'(60));
      send_word(OP_INSERT, 64'hC, SIZE_W'(61));
      send_word(OP_LOOKUP, 64'hB, '0);
      settle();
      write_csr(CSR_BYTE_LIMIT, '0);
      send_word(OP_INSERT, 64'hD, SIZE_W'(1));
      send_word(OP_INSERT, 64'hE, SIZE_W'(5));
      send_word(OP_INSERT, 64'hE, SIZE_W'(60));
      settle();
      write_csr(CSR_BYTE_LIMIT, '1);
      write_csr(CSR_MAX_ITEM, SIZE_W'(1));
      send_word(OP_INSERT, 64'hF, SIZE_W'(1));
      send_word(OP_INSERT, 64'h10, SIZE_W'(2));
      send_word(OP_LOOKUP, 64'hE, '0);
   endtask

   task automatic test_full_table();
      int i;
      settle();
      write_csr(CSR_BYTE_LIMIT, '1);
      write_csr(CSR_MAX_ITEM, '1);
      new_tag_pool();
      for (i = 0; i < 40; i++)
         send_word(OP_INSERT, tag_pool[i], SIZE_W'($urandom_range(200, 1)));
      run_random(50, 40, SIZE_W'(200), 50, 1'b0);
   endtask

   task automatic test_backpressure();
      settle();
      write_csr(CSR_BYTE_LIMIT, SIZE_W'(3000));
      write_csr(CSR_MAX_ITEM, SIZE_W'(1000));
      new_tag_pool();
      steady        = 1'b1;
      sink_hold_req = 1'b1;
      run_random(40, 10, SIZE_W'(1200), 60, 1'b0);
      settle();
      steady = 1'b0;
   endtask

   task automatic test_wide_sizes();
      settle();
      write_csr(CSR_BYTE_LIMIT, '1);
      write_csr(CSR_MAX_ITEM, '1);
      new_tag_pool();
      run_random(40, 12, '1, 60, 1'b1);
   endtask

   task automatic test_random_configs();
      int p;
      logic [SIZE_W-1:0] lim;
      logic [SIZE_W-1:0] cap;
      for (p = 0; p < 4; p++) begin
         settle();
         case (p)
            0: lim = SIZE_W'(1);
            1: lim = SIZE_W'($urandom_range(5000, 500));
            2: lim = SIZE_W'($urandom_range(200000, 20000));
            default: lim = SIZE_W'($urandom_range(2000, 100));
         endcase
         cap = (p == 0) ? SIZE_W'(1) : SIZE_W'($urandom_range(3000, 1));
         write_csr(CSR_BYTE_LIMIT, lim);
         write_csr(CSR_MAX_ITEM, cap);
         new_tag_pool();
         run_random(20, 10 + p * 4, cap + cap / 8 + 1'b1, 50, 1'b0);
      end
   endtask

   initial begin : sink_drive
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_hold_req && hold_left == 0) hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0) sink_hold_req = 1'b0;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 9);
         end
      end
   end

   always @(posedge clock) begin : word_check
      cache_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_words.size() == 0) begin
            $error("unexpected word: kind %0d victim_tag %h", rsp_kind, rsp_victim_tag);
            failures++;
         end else begin
            want = due_words[0];
            due_words.delete(0);
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, actual %0d", want.kind, rsp_kind);
               failures++;
            end
            if (rsp_victim_tag !== want.victim_tag) begin
               $error("victim_tag: expected %h, actual %h", want.victim_tag, rsp_victim_tag);
               failures++;
            end
            if (rsp_victim_bytes !== want.victim_bytes) begin
               $error("victim_bytes: expected %0d, actual %0d",
                      want.victim_bytes, rsp_victim_bytes);
               failures++;
            end
            if (rsp_total_bytes !== want.total_bytes) begin
               $error("total_bytes: expected %0d, actual %0d",
                      want.total_bytes, rsp_total_bytes);
               failures++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_last);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("** byte_budget_lru_cache_tags_unit: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int i;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_operation  = OP_LOOKUP;
      req_key_tag    = '0;
      req_item_bytes = '0;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_BYTE_LIMIT;
      csr_wdata      = '0;
      failures       = 0;
      quiet_cycles   = 0;
      steady         = 1'b0;
      sink_hold_req  = 1'b0;
      for (i = 0; i < SLOTS; i++) begin
         slot_live[i]  = 1'b0;
         slot_tag[i]   = '0;
         slot_size[i]  = '0;
         slot_stamp[i] = '0;
      end
      use_stamp   = '0;
      held_total  = '0;
      live_count  = 0;
      limit_bytes = BYTE_LIMIT_RESET;
      item_cap    = MAX_ITEM_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_budget_limits();
      test_full_table();
      test_backpressure();
      test_wide_sizes();
      test_random_configs();

      settle();
      repeat (2 * SLOTS) @(posedge clock);
      if (failures == 0) begin
         $display("** byte_budget_lru_cache_tags_unit: PASSED **");
      end else begin
         $display("** byte_budget_lru_cache_tags_unit: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
